[rtl/core/integer_set_table_unit_assert.svh]
// Assertion macros used by the scan engine of the integer set table.
`ifndef INTEGER_SET_TABLE_UNIT_ASSERT_SVH
`define INTEGER_SET_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on clk, disabled while arst_n is low.
`define IST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on clk at every edge, reset included.
`define IST_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define IST_ASSERT(label, prop, msg)
`define IST_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/core/ist_pkg.sv]
// Package with the sizes, codes and types of the integer set table.
`timescale 1ns / 1ps

package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KEY_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_PRESENT  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_SCAN,
		ENG_FINISH,
		ENG_DONE
	} eng_state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic    ok;
		status_t status;
	} res_t;

endpackage

[rtl/core/ist_engine.sv]
// Scan engine of the integer set table: key memory, valid bits and sequencer.
`timescale 1ns / 1ps
`include "integer_set_table_unit_assert.svh"

module ist_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ist_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output ist_pkg::res_t res
);

	localparam logic [ist_pkg::IDX_W-1:0] LAST_IDX = ist_pkg::IDX_W'(ist_pkg::CAPACITY - 1);

	ist_pkg::eng_state_t state_q, state_d;

	logic [ist_pkg::KEY_W-1:0]    key_mem [ist_pkg::CAPACITY];
	logic [ist_pkg::KEY_W-1:0]    rdata_s1;
	logic [ist_pkg::CAPACITY-1:0] slot_valid_q;

	ist_pkg::cmd_t             cmd_q;
	logic [ist_pkg::KEY_W-1:0] key_q;
	logic [ist_pkg::IDX_W-1:0] addr_q;
	logic                      issue_done_q;
	logic                      chk_vld_s1;
	logic [ist_pkg::IDX_W-1:0] chk_addr_s1;
	logic                      hit_q;
	logic [ist_pkg::IDX_W-1:0] hit_idx_q;
	logic                      free_found_q;
	logic [ist_pkg::IDX_W-1:0] free_idx_q;
	ist_pkg::res_t             res_q;

	logic req_fire;
	logic rd_en;
	logic wr_en;
	logic rm_en;
	logic cmp_en;
	logic hit_now;
	logic free_now;
	logic scan_end;

	assign req_fire = req_valid && req_ready;
	assign cmp_en   = chk_vld_s1 && (state_q == ist_pkg::ENG_SCAN);
	assign hit_now  = cmp_en && slot_valid_q[chk_addr_s1] && (rdata_s1 == key_q);
	assign free_now = cmp_en && !slot_valid_q[chk_addr_s1] && !free_found_q;
	assign scan_end = cmp_en && (hit_now || (chk_addr_s1 == LAST_IDX));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ist_pkg::ENG_IDLE: begin
				if (req_fire) begin
					state_d = (req.cmd == ist_pkg::CMD_CLEAR) ? ist_pkg::ENG_DONE
					                                         : ist_pkg::ENG_SCAN;
				end
			end
			ist_pkg::ENG_SCAN: begin
				if (scan_end) begin
					state_d = ist_pkg::ENG_FINISH;
				end
			end
			ist_pkg::ENG_FINISH: begin
				state_d = ist_pkg::ENG_DONE;
			end
			ist_pkg::ENG_DONE: begin
				if (res_ready) begin
					state_d = ist_pkg::ENG_IDLE;
				end
			end
			default: begin
				state_d = ist_pkg::ENG_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready = (state_q == ist_pkg::ENG_IDLE);
		res_valid = (state_q == ist_pkg::ENG_DONE);
		rd_en     = (state_q == ist_pkg::ENG_SCAN) && !issue_done_q;
		wr_en     = (state_q == ist_pkg::ENG_FINISH) && (cmd_q == ist_pkg::CMD_INSERT) &&
		            !hit_q && free_found_q;
		rm_en     = (state_q == ist_pkg::ENG_FINISH) && (cmd_q == ist_pkg::CMD_REMOVE) && hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Key memory. The sequencer never reads and writes in the same cycle, and a write
	// lands at the end of one request, before the next request issues any read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[free_idx_q] <= key_q;
		end
		if (rd_en) begin
			rdata_s1 <= key_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (req_fire && (req.cmd == ist_pkg::CMD_CLEAR)) begin
			slot_valid_q <= '0;
		end else if (wr_en) begin
			slot_valid_q[free_idx_q] <= 1'b1;
		end else if (rm_en) begin
			slot_valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// Scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			chk_vld_s1 <= rd_en;
			if (req_fire) begin
				addr_q       <= '0;
				issue_done_q <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					addr_q       <= addr_q + 1'b1;
					issue_done_q <= (addr_q == LAST_IDX);
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (free_now) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.cmd;
			key_q <= req.key;
		end
		if (rd_en) begin
			chk_addr_s1 <= addr_q;
		end
		if (hit_now) begin
			hit_idx_q <= chk_addr_s1;
		end
		if (free_now) begin
			free_idx_q <= chk_addr_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (req_fire && (req.cmd == ist_pkg::CMD_CLEAR)) begin
			res_q.ok     <= 1'b1;
			res_q.status <= ist_pkg::ST_DONE;
		end else if (state_q == ist_pkg::ENG_FINISH) begin
			unique case (cmd_q)
				ist_pkg::CMD_INSERT: begin
					if (hit_q) begin
						res_q.ok     <= 1'b1;
						res_q.status <= ist_pkg::ST_PRESENT;
					end else if (free_found_q) begin
						res_q.ok     <= 1'b1;
						res_q.status <= ist_pkg::ST_DONE;
					end else begin
						res_q.ok     <= 1'b0;
						res_q.status <= ist_pkg::ST_FULL;
					end
				end
				ist_pkg::CMD_LOOKUP, ist_pkg::CMD_REMOVE, ist_pkg::CMD_CLEAR: begin
					res_q.ok     <= hit_q;
					res_q.status <= hit_q ? ist_pkg::ST_DONE : ist_pkg::ST_NOTFOUND;
				end
				default: begin
					res_q.ok     <= 1'b0;
					res_q.status <= ist_pkg::ST_NOTFOUND;
				end
			endcase
		end
	end

	assign res = res_q;

	`IST_ASSERT(a_clear_empties, (req_fire && (req.cmd == ist_pkg::CMD_CLEAR)) |=> (slot_valid_q == '0), "clear left a slot valid")
	`IST_ASSERT(a_insert_free_slot, wr_en |-> !slot_valid_q[free_idx_q], "insert overwrote a valid slot")
	`IST_ASSERT(a_full_only_when_full, ((state_q == ist_pkg::ENG_FINISH) && (cmd_q == ist_pkg::CMD_INSERT) && !hit_q && !free_found_q) |-> (&slot_valid_q), "full reported with a free slot")
	`IST_ASSERT(a_ok_matches_status, res_valid |-> (res_q.ok == ((res_q.status == ist_pkg::ST_DONE) || (res_q.status == ist_pkg::ST_PRESENT))), "ok flag disagrees with status")

endmodule

[rtl/core/integer_set_table_unit.sv]
// Integer set table: a bounded set of 32-bit keys held in a scanned key memory.
// Commands: a clear empties the set at once; other commands scan one slot per cycle
// through the key memory read port, ending early on a hit, then register the result.
// Requests: the engine takes a new request only when idle, after the last result
// has moved to the output register; the next request is taken while a result waits.
// Reset: arst_n clears all valid bits at once, so the set is empty with no sweep.
`timescale 1ns / 1ps

module integer_set_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] ok, [2:1] status, [7:3] zero
);

	ist_pkg::req_t req;
	ist_pkg::res_t res;
	logic          res_valid;
	logic          res_ready;
	logic          out_valid_q;
	ist_pkg::res_t out_q;

	assign req.cmd = ist_pkg::cmd_t'(s_tuser);
	assign req.key = s_tdata;

	ist_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.status, out_q.ok};

endmodule
